### rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros for the rgb histogram engine
// no dependencies; taken in by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/rhe_pkg.sv
`timescale 1ns / 1ps
// rhe_pkg: types, constants and codes shared by the rgb histogram engine
// no dependencies
package rhe_pkg;

   // defaults of the top level parameters
   localparam int BIN_COUNT_DEFAULT  = 512;
   localparam int COUNT_BITS_DEFAULT = 24;

   localparam int CHANNELS    = 3;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 9;
   localparam int FUNC_W      = 2;
   localparam int COUNT_OUT_W = 24;
   localparam int HEIGHT_W    = 10;
   localparam int BAR_ROWS_W  = 10;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_SAMPLE_FORMAT = 1'd0;
   localparam logic [0:0] REG_BAR_ROWS      = 1'd1;
   localparam logic [BAR_ROWS_W-1:0] BAR_ROWS_RESET = 10'd128;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // binning constants
   localparam int BYTE_MAX     = 255;
   localparam int FIX_LOW      = -1024;   // -0.25 in q3.12
   localparam int FIX_HIGH     = 5120;    // 1.25 in q3.12
   localparam int FIX_OFFSET   = 1024;
   localparam int OFF_W        = 13;      // offset sample spans 0..6143
   localparam int FIX_SHIFT    = 11;      // 6144 = 3 * 2^11
   localparam int RECIP3       = 43691;   // ceil(2^17 / 3)
   localparam int RECIP3_W     = 16;
   localparam int RECIP3_SHIFT = 17;

   // bar height divider
   localparam int DIV_STEPS = HEIGHT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [FUNC_W-1:0]          func;
      logic signed [SAMPLE_W-1:0] red;
      logic signed [SAMPLE_W-1:0] green;
      logic signed [SAMPLE_W-1:0] blue;
      logic [INDEX_W-1:0]         bin_index;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] red_count;
      logic [COUNT_OUT_W-1:0] green_count;
      logic [COUNT_OUT_W-1:0] blue_count;
      logic [COUNT_OUT_W-1:0] red_peak;
      logic [COUNT_OUT_W-1:0] green_peak;
      logic [COUNT_OUT_W-1:0] blue_peak;
      logic [HEIGHT_W-1:0]    red_height;
      logic [HEIGHT_W-1:0]    green_height;
      logic [HEIGHT_W-1:0]    blue_height;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic clear;
      logic bin_mul;
      logic bin_calc;
      logic update;
      logic rd_index;
      logic take_count;
      logic scale;
      logic div_init;
      logic div_step;
      logic load_rsp;
      logic rsp_zero;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
   } dp_status_type;

endpackage

### rtl/rhe_ram.sv
`timescale 1ns / 1ps
// rhe_ram: generic single write port, single read port ram with registered read
// depends on rhe_pkg for default sizes
module rhe_ram #(
   parameter int WIDTH = rhe_pkg::COUNT_BITS_DEFAULT,
   parameter int DEPTH = rhe_pkg::BIN_COUNT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rhe_datapath.sv
`timescale 1ns / 1ps
// rhe_datapath: bin memories, binning lanes, peaks, bar height divider, result register
// depends on rhe_pkg and rhe_ram
module rhe_datapath #(
   parameter int BIN_COUNT  = rhe_pkg::BIN_COUNT_DEFAULT,
   parameter int COUNT_BITS = rhe_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rhe_pkg::dp_cmd_type                cmd,
   output rhe_pkg::dp_status_type             status,
   input  rhe_pkg::req_item_type              req_payload,
   input  logic                               sample_format,
   input  logic [rhe_pkg::BAR_ROWS_W-1:0]     bar_rows,
   output rhe_pkg::rsp_item_type              rsp_payload
);

   localparam int CH       = rhe_pkg::CHANNELS;
   localparam int ADDR_W   = $clog2(BIN_COUNT);
   localparam int CNT_W    = $clog2(BIN_COUNT + 1);
   localparam int OFF_W    = rhe_pkg::OFF_W;
   localparam int PROD_W   = OFF_W + CNT_W;
   localparam int Y_W      = PROD_W - rhe_pkg::FIX_SHIFT;
   localparam int QM_W     = Y_W + rhe_pkg::RECIP3_W;
   localparam int NUM_W    = COUNT_BITS + rhe_pkg::BAR_ROWS_W + 4;
   localparam int DEN_W    = COUNT_BITS + 4;
   localparam int HEIGHT_W = rhe_pkg::HEIGHT_W;
   localparam int OUT_W    = rhe_pkg::COUNT_OUT_W;
   localparam int SAMPLE_W = rhe_pkg::SAMPLE_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   rhe_pkg::req_item_type item_ff;
   rhe_pkg::rsp_item_type rsp_ff;
   logic [ADDR_W-1:0]     sweep_ff;
   logic                  sweep_last;
   logic                  in_range;
   logic [ADDR_W-1:0]     item_addr;

   logic signed [SAMPLE_W-1:0] samp       [CH];
   logic [COUNT_BITS-1:0]      rd_data    [CH];
   logic [PROD_W-1:0]          prod_ff    [CH];
   logic [ADDR_W-1:0]          addr_ff    [CH];
   logic [COUNT_BITS-1:0]      peak_ff    [CH];
   logic [COUNT_BITS-1:0]      count_ff   [CH];
   logic [NUM_W-1:0]           num_ff     [CH];
   logic [DEN_W-1:0]           den_ff     [CH];
   logic [NUM_W-1:0]           rem_ff     [CH];
   logic [NUM_W-1:0]           dsh_ff     [CH];
   logic [HEIGHT_W-1:0]        quo_ff     [CH];
   logic [OUT_W-1:0]           cnt_out    [CH];
   logic [OUT_W-1:0]           peak_out   [CH];
   logic [HEIGHT_W-1:0]        height_out [CH];

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_ff <= req_payload;
      end
   end

   assign samp[0]   = item_ff.red;
   assign samp[1]   = item_ff.green;
   assign samp[2]   = item_ff.blue;
   assign item_addr = ADDR_W'(item_ff.bin_index);
   assign in_range  = int'(item_ff.bin_index) < BIN_COUNT;

   // clear sweep address, one entry per cycle
   assign sweep_last        = sweep_ff == ADDR_W'(BIN_COUNT - 1);
   assign status.sweep_last = sweep_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.clear) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + ADDR_W'(1);
      end
   end

   for (genvar l = 0; l < CH; l++) begin : g_lane
      logic signed [SAMPLE_W-1:0] s;
      logic [OFF_W-1:0]           off;
      logic [Y_W-1:0]             y;
      logic [QM_W-1:0]            qm;
      logic [ADDR_W-1:0]          bin_byte;
      logic [ADDR_W-1:0]          bin_fix;
      logic [COUNT_BITS-1:0]      inc;
      logic [ADDR_W-1:0]          ram_waddr;
      logic [ADDR_W-1:0]          ram_raddr;
      logic [COUNT_BITS-1:0]      ram_wdata;

      assign s   = samp[l];
      assign off = OFF_W'(int'(s) + rhe_pkg::FIX_OFFSET);
      assign y   = prod_ff[l][PROD_W-1:rhe_pkg::FIX_SHIFT];
      assign qm  = QM_W'(y) * QM_W'(rhe_pkg::RECIP3);

      // byte samples clamp to 0..255
      always_comb begin
         if (int'(s) < 0) begin
            bin_byte = '0;
         end else if (int'(s) > rhe_pkg::BYTE_MAX) begin
            bin_byte = ADDR_W'(rhe_pkg::BYTE_MAX);
         end else begin
            bin_byte = ADDR_W'(s[7:0]);
         end
      end

      // q3.12 samples: under- and overflow bins, else offset * BIN_COUNT / 6144
      always_comb begin
         if (int'(s) < rhe_pkg::FIX_LOW) begin
            bin_fix = '0;
         end else if (int'(s) >= rhe_pkg::FIX_HIGH) begin
            bin_fix = ADDR_W'(BIN_COUNT - 1);
         end else begin
            bin_fix = ADDR_W'(qm >> rhe_pkg::RECIP3_SHIFT);
         end
      end

      assign inc       = (rd_data[l] == COUNT_MAX) ? rd_data[l]
                                                   : rd_data[l] + COUNT_BITS'(1);
      assign ram_raddr = cmd.rd_index ? item_addr : addr_ff[l];
      assign ram_waddr = cmd.clear ? sweep_ff : addr_ff[l];
      assign ram_wdata = cmd.clear ? '0 : inc;

      rhe_ram #(
         .WIDTH(COUNT_BITS),
         .DEPTH(BIN_COUNT)
      ) u_ram (
         .clock  (clock),
         .wr_en  (cmd.update || cmd.clear),
         .wr_addr(ram_waddr),
         .wr_data(ram_wdata),
         .rd_addr(ram_raddr),
         .rd_data(rd_data[l])
      );

      always_ff @(posedge clock) begin
         if (reset || cmd.clear) begin
            peak_ff[l] <= '0;
         end else if (cmd.update && (inc > peak_ff[l])) begin
            peak_ff[l] <= inc;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.bin_mul) begin
            prod_ff[l] <= PROD_W'(off) * PROD_W'(BIN_COUNT);
         end
         if (cmd.bin_calc) begin
            addr_ff[l] <= sample_format ? bin_fix : bin_byte;
         end
         if (cmd.take_count) begin
            count_ff[l] <= in_range ? rd_data[l] : '0;
         end
         if (cmd.scale) begin
            num_ff[l] <= NUM_W'(count_ff[l]) * NUM_W'(bar_rows);
            den_ff[l] <= (DEN_W'(peak_ff[l]) << 3) + (DEN_W'(peak_ff[l]) << 1);
         end
         // restoring division, one quotient bit per cycle, msb first
         if (cmd.div_init) begin
            rem_ff[l] <= (num_ff[l] << 3) + num_ff[l];
            dsh_ff[l] <= NUM_W'(den_ff[l]) << (HEIGHT_W - 1);
            quo_ff[l] <= '0;
         end else if (cmd.div_step) begin
            if (rem_ff[l] >= dsh_ff[l]) begin
               rem_ff[l] <= rem_ff[l] - dsh_ff[l];
               quo_ff[l] <= {quo_ff[l][HEIGHT_W-2:0], 1'b1};
            end else begin
               quo_ff[l] <= {quo_ff[l][HEIGHT_W-2:0], 1'b0};
            end
            dsh_ff[l] <= dsh_ff[l] >> 1;
         end
      end

      assign cnt_out[l]    = OUT_W'(count_ff[l]);
      assign peak_out[l]   = OUT_W'(peak_ff[l]);
      assign height_out[l] = (peak_ff[l] == '0) ? '0 : quo_ff[l];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (cmd.rsp_zero) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.red_count    <= cnt_out[0];
            rsp_ff.green_count  <= cnt_out[1];
            rsp_ff.blue_count   <= cnt_out[2];
            rsp_ff.red_peak     <= peak_out[0];
            rsp_ff.green_peak   <= peak_out[1];
            rsp_ff.blue_peak    <= peak_out[2];
            rsp_ff.red_height   <= height_out[0];
            rsp_ff.green_height <= height_out[1];
            rsp_ff.blue_height  <= height_out[2];
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

### rtl/rhe_ctrl.sv
`timescale 1ns / 1ps
// rhe_ctrl: sequencer for clear, pixel update and bin readout
// depends on rhe_pkg
module rhe_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rhe_pkg::FUNC_W-1:0]    req_func,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rhe_pkg::dp_cmd_type           cmd,
   input  rhe_pkg::dp_status_type        status
);

   localparam int DIV_CNT_W = rhe_pkg::DIV_CNT_W;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_BIN_MUL,
      S_BIN_CALC,
      S_PIX_RD,
      S_PIX_UPD,
      S_BIN_RD,
      S_TAKE,
      S_SCALE,
      S_DIV_INIT,
      S_DIV,
      S_DONE
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic                 rsp_valid_ff;
   logic                 zero_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   always_comb begin
      cmd          = '0;
      cmd.rsp_zero = zero_ff;
      state_in     = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.clear = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               case (req_func)
                  rhe_pkg::FUNC_CLEAR: state_in = S_CLEAR;
                  rhe_pkg::FUNC_PIXEL: state_in = S_BIN_MUL;
                  rhe_pkg::FUNC_READ:  state_in = S_BIN_RD;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_BIN_MUL: begin
            cmd.bin_mul = 1'b1;
            state_in    = S_BIN_CALC;
         end
         S_BIN_CALC: begin
            cmd.bin_calc = 1'b1;
            state_in     = S_PIX_RD;
         end
         S_PIX_RD: begin
            state_in = S_PIX_UPD;
         end
         S_PIX_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_BIN_RD: begin
            cmd.rd_index = 1'b1;
            state_in     = S_TAKE;
         end
         S_TAKE: begin
            cmd.take_count = 1'b1;
            state_in       = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(rhe_pkg::DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         zero_ff      <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (cmd.take_item) begin
            zero_ff <= req_func != rhe_pkg::FUNC_READ;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.div_init) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/rgb_histogram_engine_unit.sv
`timescale 1ns / 1ps
// rgb_histogram_engine_unit: top level of the three-channel pixel histogram
// depends on rhe_pkg, rhe_ctrl, rhe_datapath, rhe_ram and assert_macros.svh
//
// usage
// - req channel (valid/ready) carries one item: func, red, green, blue, bin_index
//   func clear wipes all bins and peaks, pixel bins one rgb sample per channel,
//   read returns the counts and bar heights of one bin and the channel peaks
// - rsp channel (valid/ready) returns exactly one item per request item
// - csr port (apb style, pready tied high): sample_format at 0x0, bar_rows at 0x4
// - one item is worked on at a time: req_ready stays low from accept until
//   the result is loaded into the output register; an unused func goes
//   straight to the result stage
// - pixel rate is set by the bin calculation (multiply, then bin select) and the
//   read-modify-write through the registered-read bin rams, read rate by the
//   ten-step restoring divider that forms the bar heights
// - reset: a clearing pass writes zero to every bin with req_ready low; csr
//   writes are taken as usual during it
// - a stalled receiver holds the result in the output register; the next
//   item is still accepted and runs until its own result is due
module rgb_histogram_engine_unit #(
   parameter int BIN_COUNT  = rhe_pkg::BIN_COUNT_DEFAULT,
   parameter int COUNT_BITS = rhe_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rhe_pkg::req_item_type            req_payload,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rhe_pkg::rsp_item_type            rsp_payload,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rhe_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rhe_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rhe_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

`include "assert_macros.svh"

   localparam int BAR_ROWS_W = rhe_pkg::BAR_ROWS_W;
   localparam int CSR_DATA_W = rhe_pkg::CSR_DATA_W;

   rhe_pkg::dp_cmd_type    dp_cmd;
   rhe_pkg::dp_status_type dp_status;

   logic                  sample_format_ff;
   logic [BAR_ROWS_W-1:0] bar_rows_ff;
   logic                  csr_wr;
   logic [0:0]            csr_index;

   // register writes land on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[rhe_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= 1'b0;
         bar_rows_ff      <= rhe_pkg::BAR_ROWS_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            rhe_pkg::REG_SAMPLE_FORMAT: sample_format_ff <= csr_pwdata[0];
            rhe_pkg::REG_BAR_ROWS:      bar_rows_ff <= csr_pwdata[BAR_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // read-back mux
   always_comb begin
      case (csr_index)
         rhe_pkg::REG_SAMPLE_FORMAT: csr_prdata = CSR_DATA_W'(sample_format_ff);
         rhe_pkg::REG_BAR_ROWS:      csr_prdata = CSR_DATA_W'(bar_rows_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // sequencer
   rhe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func (req_payload.func),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (dp_cmd),
      .status   (dp_status)
   );

   // bin rams, binning lanes, divider and result register
   rhe_datapath #(
      .BIN_COUNT (BIN_COUNT),
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .req_payload  (req_payload),
      .sample_format(sample_format_ff),
      .bar_rows     (bar_rows_ff),
      .rsp_payload  (rsp_payload)
   );

   // an accepted item closes the input in the cycle after
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   // a new result only appears out of the busy phase of an item
   `ASSERT_IMPLIES(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))
   // clearing sweep and pixel update never share the ram write port
   `ASSERT_ALWAYS(a_wr_excl, clock, reset, !(dp_cmd.update && dp_cmd.clear))
   // a bar_rows write takes effect on the next cycle
   `ASSERT_NEXT(a_rows_write, clock, reset, csr_wr && (csr_index == rhe_pkg::REG_BAR_ROWS), bar_rows_ff == $past(csr_pwdata[9:0]))

endmodule
